// ===== rtl/core/cvkt_pkg.sv =====
// Shared types, codes and saturating arithmetic helpers for the tracker.
// Used by the lane, the noise generator and the top level; no dependencies.
package cvkt_pkg;

    // Item kinds carried on the input tuser.
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_AXES  = 2'd0;
    localparam logic [1:0] REG_DT    = 2'd1;
    localparam logic [1:0] REG_PVAR  = 2'd2;
    localparam logic [1:0] REG_MVAR  = 2'd3;

    // Result status codes.
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_SINGULAR = 1'b1;

    localparam logic signed [63:0] S32_MAX_W = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN_W = 64'shFFFF_FFFF_8000_0000;

    // Control toward one lane.
    typedef struct packed {
        logic start;
        logic op;
    } t_lane_ctl;

    // Status back from one lane.
    typedef struct packed {
        logic done;
        logic s_zero;
    } t_lane_sts;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX_W) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN_W) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return sat32(s);
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] s;
        s = 64'(a) - 64'(b);
        return sat32(s);
    endfunction

    // Magnitude of a signed 32-bit value; the most negative value gives 2^31.
    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        logic [31:0] u;
        u = $unsigned(a);
        return a[31] ? (~u + 32'd1) : u;
    endfunction

endpackage

// ===== rtl/core/cvkt_qgen.sv =====
// Process noise term generator: q*dt^4/4, q*dt^3/2 and q*dt^2.
// Depends on cvkt_pkg; one shared multiplier stepped through the power chain.
module cvkt_qgen import cvkt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_dt,
    input  logic signed [31:0] i_q,
    output logic               o_done,
    output logic signed [31:0] o_q00,
    output logic signed [31:0] o_q01,
    output logic signed [31:0] o_q11
);

    logic               r_busy;
    logic [2:0]         r_step;
    logic               r_done;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_dt2, r_dt3, r_dt4;
    logic signed [31:0] r_q00, r_q01, r_q11;
    logic signed [31:0] mul_a, mul_b;
    logic signed [31:0] prod_v;

    assign prod_v = sat32(r_prod >>> FRAC_BITS);

    // Operand selection for each step of the power chain.
    always_comb begin
        mul_a = i_dt;
        mul_b = i_dt;
        case (r_step)
            3'd1, 3'd2: begin mul_a = prod_v; mul_b = i_dt;  end
            3'd3:       begin mul_a = i_q;    mul_b = r_dt2; end
            3'd4:       begin mul_a = i_q;    mul_b = r_dt3; end
            3'd5:       begin mul_a = i_q;    mul_b = r_dt4; end
            default:    begin mul_a = i_dt;   mul_b = i_dt;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Step sequencer; each step captures the previous product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_step <= '0;
                end
            end else begin
                r_step <= r_step + 3'd1;
                case (r_step)
                    3'd1:    r_dt2 <= prod_v;
                    3'd2:    r_dt3 <= prod_v;
                    3'd3:    r_dt4 <= prod_v;
                    3'd4:    r_q11 <= prod_v;
                    3'd5:    r_q01 <= prod_v >>> 1;
                    3'd6: begin
                        r_q00  <= prod_v >>> 2;
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_q00  = r_q00;
    assign o_q01  = r_q01;
    assign o_q11  = r_q11;

endmodule

// ===== rtl/core/cvkt_lane.sv =====
// One axis of the tracker: state, one multiplier and a pair of gain dividers.
// Depends on cvkt_pkg; instantiated once per axis by the top level.
module cvkt_lane import cvkt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_ctl          i_ctl,
    input  logic signed [31:0] i_dt,
    input  logic signed [31:0] i_r,
    input  logic signed [31:0] i_q00,
    input  logic signed [31:0] i_q01,
    input  logic signed [31:0] i_q11,
    input  logic signed [31:0] i_meas,
    output t_lane_sts          o_sts,
    output logic signed [31:0] o_pos,
    output logic signed [31:0] o_vel
);

    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_PRED = 4'b0010,
        L_DIV  = 4'b0100,
        L_UPD  = 4'b1000
    } t_lane_st;

    t_lane_st           r_st;
    logic [2:0]         r_step;
    logic               r_done;
    logic signed [31:0] r_pos, r_vel, r_pp, r_pv, r_vp, r_vv;
    logic signed [31:0] r_t0, r_t1, r_k0, r_k1, r_y;
    logic signed [63:0] r_prod;
    logic [31:0]        r_den, r_rem0, r_rem1;
    logic [NUM_W-1:0]   r_dq0, r_dq1;
    logic               r_neg0, r_neg1;
    logic [CNT_W-1:0]   r_dcnt;

    logic signed [31:0] mul_a, mul_b, prod_v, s_val, pred_t1;
    logic [32:0]        sh0, sh1;
    logic               ge0, ge1;
    logic signed [63:0] quo0, quo1;

    assign prod_v  = sat32(r_prod >>> FRAC_BITS);
    assign s_val   = add_sat(r_pp, i_r);
    assign pred_t1 = add_sat(r_pv, prod_v);

    // Restoring division, one quotient bit per cycle for both gains.
    assign sh0 = {r_rem0, r_dq0[NUM_W-1]};
    assign sh1 = {r_rem1, r_dq1[NUM_W-1]};
    assign ge0 = sh0 >= {1'b0, r_den};
    assign ge1 = sh1 >= {1'b0, r_den};
    assign quo0 = r_neg0 ? -$signed(64'(r_dq0)) : $signed(64'(r_dq0));
    assign quo1 = r_neg1 ? -$signed(64'(r_dq1)) : $signed(64'(r_dq1));

    // Multiplier operands for each step of predict and update.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_st)
            L_PRED: begin
                case (r_step)
                    3'd0:    begin mul_a = i_dt;  mul_b = r_vp; end
                    3'd1:    begin mul_a = i_dt;  mul_b = r_vv; end
                    3'd2:    begin mul_a = r_vel; mul_b = i_dt; end
                    3'd3:    begin mul_a = r_t1;  mul_b = i_dt; end
                    default: ;
                endcase
            end
            L_UPD: begin
                case (r_step)
                    3'd0:    begin mul_a = r_k0; mul_b = r_y;  end
                    3'd1:    begin mul_a = r_k1; mul_b = r_y;  end
                    3'd2:    begin mul_a = r_k1; mul_b = r_pp; end
                    3'd3:    begin mul_a = r_k1; mul_b = r_pv; end
                    3'd4:    begin mul_a = r_k0; mul_b = r_pp; end
                    3'd5:    begin mul_a = r_k0; mul_b = r_pv; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Lane sequencer; each step writes back the product issued one step earlier.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_step <= '0;
            r_done <= 1'b0;
            r_pos  <= '0;
            r_vel  <= '0;
            r_pp   <= '0;
            r_pv   <= '0;
            r_vp   <= '0;
            r_vv   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                L_IDLE: begin
                    if (i_ctl.start) begin
                        r_step <= '0;
                        if (i_ctl.op == OP_PREDICT) begin
                            r_st <= L_PRED;
                        end else begin
                            r_den  <= abs32(s_val);
                            r_rem0 <= '0;
                            r_rem1 <= '0;
                            r_dq0  <= {abs32(r_pp), {FRAC_BITS{1'b0}}};
                            r_dq1  <= {abs32(r_vp), {FRAC_BITS{1'b0}}};
                            r_neg0 <= r_pp[31] ^ s_val[31];
                            r_neg1 <= r_vp[31] ^ s_val[31];
                            r_dcnt <= '0;
                            r_st   <= L_DIV;
                        end
                    end
                end
                L_PRED: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1: r_t0 <= add_sat(r_pp, prod_v);
                        3'd2: begin
                            r_t1 <= pred_t1;
                            r_pv <= add_sat(pred_t1, i_q01);
                            r_vp <= add_sat(add_sat(r_vp, prod_v), i_q01);
                            r_vv <= add_sat(r_vv, i_q11);
                        end
                        3'd3: r_pos <= add_sat(r_pos, prod_v);
                        3'd4: begin
                            r_pp   <= add_sat(add_sat(r_t0, prod_v), i_q00);
                            r_st   <= L_IDLE;
                            r_done <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                L_DIV: begin
                    if (r_dcnt != CNT_W'(NUM_W)) begin
                        r_rem0 <= ge0 ? 32'(sh0 - {1'b0, r_den}) : sh0[31:0];
                        r_rem1 <= ge1 ? 32'(sh1 - {1'b0, r_den}) : sh1[31:0];
                        r_dq0  <= {r_dq0[NUM_W-2:0], ge0};
                        r_dq1  <= {r_dq1[NUM_W-2:0], ge1};
                        r_dcnt <= r_dcnt + 1'b1;
                    end else begin
                        r_k0   <= sat32(quo0);
                        r_k1   <= sat32(quo1);
                        r_y    <= sub_sat(i_meas, r_pos);
                        r_step <= '0;
                        r_st   <= L_UPD;
                    end
                end
                L_UPD: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1: r_pos <= add_sat(r_pos, prod_v);
                        3'd2: r_vel <= add_sat(r_vel, prod_v);
                        3'd3: r_vp  <= sub_sat(r_vp, prod_v);
                        3'd4: r_vv  <= sub_sat(r_vv, prod_v);
                        3'd5: r_pp  <= sub_sat(r_pp, prod_v);
                        3'd6: begin
                            r_pv   <= sub_sat(r_pv, prod_v);
                            r_st   <= L_IDLE;
                            r_done <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                default: r_st <= L_IDLE;
            endcase
        end
    end

    assign o_sts.done   = r_done;
    assign o_sts.s_zero = (s_val == 32'sd0);
    assign o_pos        = r_pos;
    assign o_vel        = r_vel;

endmodule

// ===== rtl/core/constant_velocity_kalman_tracker_top.sv =====
// Top level of the constant-velocity tracker: ports, registers, lanes, merge.
// Depends on cvkt_pkg, cvkt_qgen and cvkt_lane.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: meas_x, meas_y, meas_z; tuser: opcode
//  m_axis    out        tdata: pos/vel per axis; tuser: status
//  APB       in/out     axes_in_use, time_step, process_variance, measurement_variance
//
// A predict item runs the noise term chain, then a 5-step multiply sequence in each lane,
// then the lanes are collected. An update item runs one bit-serial division cycle per
// numerator bit (32+FRAC_BITS bits, 48 at Q16.16), a step to form the gains, 7 multiply
// steps and the collection. A singular update skips the lanes and goes straight to S_DONE.
// Reset clears the lane state and pending result and restores the register defaults.
// A new item is taken once the previous result sits in the output register.
module constant_velocity_kalman_tracker_top import cvkt_pkg::*; #(
    parameter int MAX_AXES  = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // meas_x, meas_y, meas_z
    input  logic         s_axis_tuser,   // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,   // pos_x, vel_x, pos_y, vel_y, pos_z, vel_z
    output logic         m_axis_tuser,   // status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_QGEN = 4'b0010,
        S_RUN  = 4'b0100,
        S_DONE = 4'b1000
    } t_top_st;

    t_top_st            r_st;
    logic [1:0]         r_axes;
    logic [30:0]        r_dt, r_pvar, r_mvar;
    logic               r_op;
    logic               r_status;
    logic signed [31:0] r_meas [MAX_AXES];
    logic               r_ovalid;
    logic [191:0]       r_odata;
    logic               r_ostatus;

    logic               in_acc, cfg_wr, lanes_go, qgen_go, qgen_done, singular;
    logic [1:0]         n_axes;
    logic signed [31:0] dt_s, q_s, r_s, q00, q01, q11;
    t_lane_ctl          lane_ctl [MAX_AXES];
    t_lane_sts          lane_sts [MAX_AXES];
    logic signed [31:0] lane_pos [MAX_AXES];
    logic signed [31:0] lane_vel [MAX_AXES];
    logic [191:0]       merged;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign dt_s   = $signed({1'b0, r_dt});
    assign q_s    = $signed({1'b0, r_pvar});
    assign r_s    = $signed({1'b0, r_mvar});

    // Active axis count, zero treated as one and clipped to the lane count.
    assign n_axes = (r_axes == 2'd0) ? 2'd1 :
                    (r_axes > 2'(MAX_AXES)) ? 2'(MAX_AXES) : r_axes;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axes <= 2'd1;
            r_dt   <= 31'(1) << FRAC_BITS;
            r_pvar <= '0;
            r_mvar <= 31'(1) << FRAC_BITS;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_AXES: r_axes <= pwdata[1:0];
                REG_DT:   r_dt   <= pwdata[30:0];
                REG_PVAR: r_pvar <= pwdata[30:0];
                REG_MVAR: r_mvar <= pwdata[30:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_AXES: prdata = {30'd0, r_axes};
            REG_DT:   prdata = {1'b0, r_dt};
            REG_PVAR: prdata = {1'b0, r_pvar};
            REG_MVAR: prdata = {1'b0, r_mvar};
            default:  prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // Singular when any active axis has a zero innovation variance.
    always_comb begin
        singular = 1'b0;
        for (int g = 0; g < MAX_AXES; g++) begin
            if (2'(g) < n_axes && lane_sts[g].s_zero) begin
                singular = 1'b1;
            end
        end
    end

    cvkt_qgen #(.FRAC_BITS(FRAC_BITS)) u_qgen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (qgen_go),
        .i_dt    (dt_s),
        .i_q     (q_s),
        .o_done  (qgen_done),
        .o_q00   (q00),
        .o_q01   (q01),
        .o_q11   (q11)
    );

    assign qgen_go  = in_acc && (s_axis_tuser == OP_PREDICT);
    assign lanes_go = (r_st == S_QGEN && qgen_done) ||
                      (r_st == S_IDLE && in_acc && s_axis_tuser == OP_UPDATE && !singular);

    // One lane per axis.
    for (genvar g = 0; g < MAX_AXES; g++) begin : g_lane
        assign lane_ctl[g].start = lanes_go && (2'(g) < n_axes);
        assign lane_ctl[g].op    = (r_st == S_QGEN) ? OP_PREDICT : OP_UPDATE;
        cvkt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl[g]),
            .i_dt    (dt_s),
            .i_r     (r_s),
            .i_q00   (q00),
            .i_q01   (q01),
            .i_q11   (q11),
            .i_meas  (r_meas[g]),
            .o_sts   (lane_sts[g]),
            .o_pos   (lane_pos[g]),
            .o_vel   (lane_vel[g])
        );
    end

    // Merge lane estimates; axes without a lane read as zero.
    always_comb begin
        merged = '0;
        for (int g = 0; g < MAX_AXES; g++) begin
            merged[64*g +: 32]      = lane_pos[g];
            merged[64*g + 32 +: 32] = lane_vel[g];
        end
    end

    // Item sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
            r_status <= ST_OK;
        end else begin
            // In S_DONE an accepted result is always replaced by the new one below.
            if (m_axis_tvalid && m_axis_tready && r_st != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (in_acc) begin
                        for (int g = 0; g < MAX_AXES; g++) begin
                            r_meas[g] <= s_axis_tdata[32*g +: 32];
                        end
                        r_op <= s_axis_tuser;
                        if (s_axis_tuser == OP_PREDICT) begin
                            r_status <= ST_OK;
                            r_st     <= S_QGEN;
                        end else if (singular) begin
                            r_status <= ST_SINGULAR;
                            r_st     <= S_DONE;
                        end else begin
                            r_status <= ST_OK;
                            r_st     <= S_RUN;
                        end
                    end
                end
                S_QGEN: begin
                    if (qgen_done) begin
                        r_st <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (lane_sts[0].done) begin
                        r_st <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid  <= 1'b1;
                        r_odata   <= merged;
                        r_ostatus <= (r_op == OP_UPDATE) ? r_status : ST_OK;
                        r_st      <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ostatus;

endmodule

// ===== rtl/core/cvkt_checker.sv =====
// Port-level checks on the tracker's handshakes and item flow.
// Depends only on the top level's ports; bound to the top level below.
module cvkt_assertions (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // One item at a time: input closes right after an item is taken.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still open after accepting an item");

    // Leaving reset, the block is idle with no result pending.
    a_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> s_axis_tready && !m_axis_tvalid)
        else $error("not idle after reset");

    // Input reopens only with a result presented.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(s_axis_tready) |-> m_axis_tvalid)
        else $error("input reopened without a result");

endmodule

bind constant_velocity_kalman_tracker_top cvkt_assertions u_cvkt_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/cvkt_checker.sv =====
`timescale 1ns / 100ps
// Checker for the constant-velocity tracker: tracks register writes, predicts each result
// from accepted input items and compares it with the output channel. Depends on cvkt_pkg.
module cvkt_checker import cvkt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [95:0]  i_in_data,    // meas_x, meas_y, meas_z
    input  logic         i_in_user,    // opcode
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [191:0] i_out_data,   // pos_x, vel_x, pos_y, vel_y, pos_z, vel_z
    input  logic         i_out_user,   // status
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [3:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    input  logic         i_pready,
    output int           o_fail_count,
    output int           o_pending
);

    localparam int FRAC = 16;
    localparam int AXES_MAX = 3;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    typedef struct packed {
        logic [191:0] est;
        logic         status;
    } track_t;

    track_t expected_tracks[$];

    // Shadow of the tracker state and its registers.
    longint est_st[6];
    longint cov_st[12];
    int     axes_cfg;
    longint dt_cfg, q_cfg, r_cfg;

    string field_names[6] = '{"pos_x", "vel_x", "pos_y", "vel_y", "pos_z", "vel_z"};

    function automatic longint clamp32(input longint v);
        if (v > MAX32) return MAX32;
        if (v < MIN32) return MIN32;
        return v;
    endfunction

    // Fixed-point product, rounded toward minus infinity by the arithmetic shift.
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> FRAC);
    endfunction

    function automatic longint qdiv(input longint num, input longint den);
        return clamp32((num * (64'sd1 <<< FRAC)) / den);
    endfunction

    task automatic advance_tracker(input logic op, input logic [95:0] meas, output track_t r);
        int n;
        longint dt2, dt3, dt4, q00, q01, q11;
        longint p00, p01, p10, p11, t0, t1, k0, k1, z, y;
        longint s[AXES_MAX];
        bit singular;
        n = axes_cfg;
        if (n == 0) n = 1;
        if (n > AXES_MAX) n = AXES_MAX;
        r.status = ST_OK;
        if (op == OP_PREDICT) begin
            dt2 = qmul(dt_cfg, dt_cfg);
            dt3 = qmul(dt2, dt_cfg);
            dt4 = qmul(dt3, dt_cfg);
            q00 = qmul(q_cfg, dt4) >>> 2;
            q01 = qmul(q_cfg, dt3) >>> 1;
            q11 = qmul(q_cfg, dt2);
            for (int d = 0; d < n; d++) begin
                p00 = cov_st[4*d]; p01 = cov_st[4*d+1];
                p10 = cov_st[4*d+2]; p11 = cov_st[4*d+3];
                t0 = clamp32(p00 + qmul(dt_cfg, p10));
                t1 = clamp32(p01 + qmul(dt_cfg, p11));
                cov_st[4*d]   = clamp32(clamp32(t0 + qmul(t1, dt_cfg)) + q00);
                cov_st[4*d+1] = clamp32(t1 + q01);
                cov_st[4*d+2] = clamp32(clamp32(p10 + qmul(p11, dt_cfg)) + q01);
                cov_st[4*d+3] = clamp32(p11 + q11);
                est_st[2*d] = clamp32(est_st[2*d] + qmul(est_st[2*d+1], dt_cfg));
            end
        end else begin
            singular = 0;
            for (int d = 0; d < n; d++) begin
                s[d] = clamp32(cov_st[4*d] + r_cfg);
                if (s[d] == 0) singular = 1;
            end
            if (singular) begin
                r.status = ST_SINGULAR;
            end else begin
                for (int d = 0; d < n; d++) begin
                    p00 = cov_st[4*d]; p01 = cov_st[4*d+1];
                    p10 = cov_st[4*d+2]; p11 = cov_st[4*d+3];
                    k0 = qdiv(p00, s[d]);
                    k1 = qdiv(p10, s[d]);
                    z = longint'($signed(meas[32*d +: 32]));
                    y = clamp32(z - est_st[2*d]);
                    est_st[2*d]   = clamp32(est_st[2*d] + qmul(k0, y));
                    est_st[2*d+1] = clamp32(est_st[2*d+1] + qmul(k1, y));
                    cov_st[4*d]   = clamp32(p00 - qmul(k0, p00));
                    cov_st[4*d+1] = clamp32(p01 - qmul(k0, p01));
                    cov_st[4*d+2] = clamp32(p10 - qmul(k1, p00));
                    cov_st[4*d+3] = clamp32(p11 - qmul(k1, p01));
                end
            end
        end
        for (int i = 0; i < 6; i++) r.est[32*i +: 32] = est_st[i][31:0];
    endtask

    initial o_fail_count = 0;
    assign o_pending = expected_tracks.size();

    // Results are checked before new items are queued: a result never belongs to
    // an item accepted at the same edge.
    always @(posedge i_clk) begin
        track_t exp_t;
        track_t got;
        if (!i_rst_n) begin
            foreach (est_st[i]) est_st[i] = 0;
            foreach (cov_st[i]) cov_st[i] = 0;
            axes_cfg = 1;
            dt_cfg = 64'sd65536;
            q_cfg = 0;
            r_cfg = 64'sd65536;
            expected_tracks.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_tracks.size() == 0) begin
                    $error("result item with no expectation waiting");
                    o_fail_count++;
                end else begin
                    exp_t = expected_tracks.pop_front();
                    got.est = i_out_data;
                    got.status = i_out_user;
                    for (int i = 0; i < 6; i++) begin
                        if (got.est[32*i +: 32] !== exp_t.est[32*i +: 32]) begin
                            $error("%s expected %h actual %h", field_names[i],
                                   exp_t.est[32*i +: 32], got.est[32*i +: 32]);
                            o_fail_count++;
                        end
                    end
                    if (got.status !== exp_t.status) begin
                        $error("status expected %b actual %b", exp_t.status, got.status);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_tracker(i_in_user, i_in_data, exp_t);
                expected_tracks.push_back(exp_t);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_AXES: axes_cfg = int'(i_pwdata[1:0]);
                    REG_DT:   dt_cfg = longint'(i_pwdata[30:0]);
                    REG_PVAR: q_cfg = longint'(i_pwdata[30:0]);
                    REG_MVAR: r_cfg = longint'(i_pwdata[30:0]);
                    default:  ;
                endcase
            end
        end
    end

endmodule

// ===== sim/tb_constant_velocity_kalman_tracker_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the constant-velocity tracker: clock, reset, register writes and
// item stimulus with random gaps and stalls. Depends on cvkt_pkg and cvkt_checker.
module tb_constant_velocity_kalman_tracker_top import cvkt_pkg::*;;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;   // meas_x, meas_y, meas_z
    logic         s_axis_tuser = 1'b0; // opcode
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;        // pos_x, vel_x, pos_y, vel_y, pos_z, vel_z
    logic         m_axis_tuser;        // status
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count;
    int pending;
    int burst_left = 0;
    bit no_gaps = 0;
    int stall_cyc = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    constant_velocity_kalman_tracker_top dut (.*);

    cvkt_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver stalls follow a pattern that steps through four modes in turn.
    always @(negedge i_clk) begin
        stall_cyc <= stall_cyc + 1;
        case ((stall_cyc / 500) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= ((stall_cyc % 7) < 3);
            default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the write.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    task automatic set_tracker(input logic [31:0] axes, input logic [31:0] dt,
                               input logic [31:0] q, input logic [31:0] r);
        wait_drained();
        apb_write(REG_AXES, axes);
        apb_write(REG_DT, dt);
        apb_write(REG_PVAR, q);
        apb_write(REG_MVAR, r);
    endtask

    // Sends one item, holding valid until the handshake; valid stays high afterwards.
    task automatic send_item(input logic op, input logic [31:0] mx,
                             input logic [31:0] my, input logic [31:0] mz);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {mz, my, mx};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_meas();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_reg();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0002_0000);
        endcase
    endfunction

    task automatic random_item();
        if (!no_gaps && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left > 0) burst_left--;
        send_item($urandom_range(0, 1) ? OP_UPDATE : OP_PREDICT,
                  rand_meas(), rand_meas(), rand_meas());
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register defaults after reset: zero state stays zero, gain of zero.
        send_item(OP_PREDICT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_item(OP_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
        // Zero covariance with zero measurement noise is a singular innovation.
        set_tracker(1, 32'h0001_0000, 0, 0);
        send_item(OP_UPDATE, 32'h0001_0000, 32'h0, 32'h0);
        // All three axes with unit noise.
        set_tracker(3, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_item(OP_PREDICT, 0, 0, 0);
        send_item(OP_PREDICT, 0, 0, 0);
        send_item(OP_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000);
        send_item(OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFD_0000);
        send_item(OP_PREDICT, 0, 0, 0);
        send_item(OP_UPDATE, 32'h0, 32'hFFFF_FFFF, 32'h1);
        // Largest step and noise, driving the products into saturation.
        set_tracker(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(OP_PREDICT, 0, 0, 0);
        send_item(OP_PREDICT, 0, 0, 0);
        send_item(OP_UPDATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // Zero axes acts as one; zero step and zero noise.
        set_tracker(0, 0, 0, 0);
        send_item(OP_PREDICT, 0, 0, 0);
        send_item(OP_UPDATE, 32'h0000_8000, 32'h1234_5678, 32'h0);
        set_tracker(2, 32'h0000_8000, 32'h0000_0100, 32'h0000_4000);
        send_item(OP_PREDICT, 0, 0, 0);
        send_item(OP_UPDATE, 32'h0002_0000, 32'hFFFE_0000, 32'h7FFF_FFFF);
        send_item(OP_PREDICT, 0, 0, 0);

        // Random phases, each with its own register setting.
        for (int phase = 0; phase < 14; phase++) begin
            set_tracker($urandom_range(0, 3), rand_reg(), rand_reg(), rand_reg());
            no_gaps = (phase % 4 == 1);
            burst_left = 0;
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 49) == 0) wait_drained();
                random_item();
            end
        end

        wait_drained();
        repeat (30) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
